/* hw/rtl/pnrs_pkg.sv */
// Shared types and constants for the Pareto rank sorter.
// Holds the stored individual record and the domination test.
// No dependencies.
package pnrs_pkg;

	localparam int ID_W      = 32;
	localparam int VAL_W     = 32;
	localparam int NUM_OBJ   = 4;
	localparam int CNT_W     = 3;
	localparam int IN_DATA_W = ID_W + NUM_OBJ * VAL_W;
	localparam int OUT_DATA_W = 32;
	localparam int POS_W     = 6;
	localparam int RANK_W    = 6;
	localparam int FRONT_W   = 7;

	typedef logic signed [VAL_W-1:0] value_t;

	typedef struct packed {
		value_t [NUM_OBJ-1:0] obj;
		logic [ID_W-1:0]      ident;
	} indiv_t;

	// true when individual a is dominated by individual b
	function automatic logic is_dominated(indiv_t a, indiv_t b, logic [CNT_W-1:0] n_obj);
		logic no_worse;
		logic all_eq;
		no_worse = 1'b1;
		all_eq   = 1'b1;
		for (int k = 0; k < NUM_OBJ; k++) begin
			if (CNT_W'(k) < n_obj) begin
				if (a.obj[k] < b.obj[k])
					no_worse = 1'b0;
				if (a.obj[k] != b.obj[k])
					all_eq = 1'b0;
			end
		end
		return no_worse && (!all_eq || (a.ident < b.ident));
	endfunction

endpackage

/* hw/rtl/pareto_nondominated_rank_sorter_top.sv */
// Pareto rank sorter top level: loading, pairwise compare, front peeling, emit.
// Depends on pnrs_pkg.
// Loading takes one item per cycle. On the final item, compare visits all n*n pairs
// through the two-port population memory, then each front is peeled in a sweep of
// the domination memory, then results leave one at a time, each rank read before it
// is sent, with the output waiting while m_tready holds it back.
// Reset clears control state and sets objective_count to 2; memories are not cleared.
module pareto_nondominated_rank_sorter_top #(
	parameter int POP_SIZE = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [2:0]                        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// ident, objective_a, objective_b, objective_c, objective_d
	input  logic [pnrs_pkg::IN_DATA_W-1:0]    s_tdata,
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// position, pareto_rank, in_front, highest_rank, front_size, overflowed, zero fill
	output logic [pnrs_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                              m_tlast
);
	import pnrs_pkg::*;

	localparam int IW = $clog2(POP_SIZE);
	localparam int CW = $clog2(POP_SIZE + 1);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_CMP      = 3'd1;
	localparam logic [2:0] ST_CMP_END  = 3'd2;
	localparam logic [2:0] ST_PEEL     = 3'd3;
	localparam logic [2:0] ST_PEEL_END = 3'd4;
	localparam logic [2:0] ST_EMIT_RD  = 3'd5;
	localparam logic [2:0] ST_EMIT_WR  = 3'd6;

	localparam logic REG_OBJ_COUNT = 1'b0;

	logic [2:0]          state_q;
	logic [CNT_W-1:0]    obj_cnt_q;
	logic [CW-1:0]       loaded_q;
	logic                overflow_q;
	logic [IW-1:0]       ci_q, cj_q, pi_q, p_q, cur_q;
	logic [CW-1:0]       front_q;
	logic [POP_SIZE-1:0] acc_q, done_q, newly_q;

	logic                cv_s1, clast_s1;
	logic [IW-1:0]       ci_s1, cj_s1;
	logic                pv_s1;
	logic [IW-1:0]       pi_s1;

	indiv_t              pop_mem [POP_SIZE];
	logic [POP_SIZE-1:0] dom_mem [POP_SIZE];
	logic [IW-1:0]       rank_mem [POP_SIZE];

	indiv_t              rd_a_s1, rd_b_s1;
	logic [POP_SIZE-1:0] dom_rd_s1;
	logic [IW-1:0]       rank_rd_s1;

	logic                m_valid_q, m_last_q;
	logic [OUT_DATA_W-1:0] m_data_q;

	logic [CW-1:0]       nm1_w;
	logic [IW-1:0]       last_idx;
	logic [CNT_W-1:0]    n_obj;
	logic                dom_bit;
	logic                hit;
	logic [POP_SIZE-1:0] loaded_mask, hit_vec, newly_next, done_next;
	logic                all_done;
	logic                s_acc, cfg_wr, out_free;
	indiv_t              in_rec;

	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == REG_OBJ_COUNT) ? 32'(obj_cnt_q) : 32'd0;
	assign cfg_wr   = psel && penable && pwrite;
	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;

	assign nm1_w    = loaded_q - CW'(1);
	assign last_idx = nm1_w[IW-1:0];
	assign n_obj    = (obj_cnt_q > CNT_W'(NUM_OBJ)) ? CNT_W'(NUM_OBJ) : obj_cnt_q;
	assign dom_bit  = is_dominated(rd_a_s1, rd_b_s1, n_obj);

	always_comb begin
		in_rec.ident = s_tdata[ID_W-1:0];
		for (int k = 0; k < NUM_OBJ; k++)
			in_rec.obj[k] = s_tdata[ID_W + k*VAL_W +: VAL_W];
	end

	for (genvar m = 0; m < POP_SIZE; m++) begin : g_mask
		assign loaded_mask[m] = (CW'(m) < loaded_q);
	end

	assign hit        = pv_s1 && !done_q[pi_s1] && ((dom_rd_s1 & ~done_q) == '0);
	assign hit_vec    = hit ? (POP_SIZE'(1) << pi_s1) : '0;
	assign newly_next = newly_q | hit_vec;
	assign done_next  = done_q | newly_next;
	assign all_done   = &(done_next | ~loaded_mask);

	// memories
	always_ff @(posedge clk) begin
		if (s_acc && (loaded_q < CW'(POP_SIZE)))
			pop_mem[loaded_q[IW-1:0]] <= in_rec;
		rd_a_s1 <= pop_mem[ci_q];
		rd_b_s1 <= pop_mem[cj_q];
		if (cv_s1 && clast_s1)
			dom_mem[ci_s1] <= acc_q | (dom_bit ? (POP_SIZE'(1) << cj_s1) : '0);
		dom_rd_s1 <= dom_mem[pi_q];
		if (hit)
			rank_mem[pi_s1] <= cur_q;
		if (state_q == ST_EMIT_RD)
			rank_rd_s1 <= rank_mem[p_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			obj_cnt_q  <= CNT_W'(2);
			loaded_q   <= '0;
			overflow_q <= 1'b0;
			ci_q       <= '0;
			cj_q       <= '0;
			pi_q       <= '0;
			p_q        <= '0;
			cur_q      <= '0;
			front_q    <= '0;
			acc_q      <= '0;
			done_q     <= '0;
			newly_q    <= '0;
			cv_s1      <= 1'b0;
			clast_s1   <= 1'b0;
			ci_s1      <= '0;
			cj_s1      <= '0;
			pv_s1      <= 1'b0;
			pi_s1      <= '0;
			m_valid_q  <= 1'b0;
			m_last_q   <= 1'b0;
			m_data_q   <= '0;
		end else begin
			if (cfg_wr && (paddr[2] == REG_OBJ_COUNT))
				obj_cnt_q <= pwdata[CNT_W-1:0];
			if (m_valid_q && m_tready && (state_q != ST_EMIT_WR))
				m_valid_q <= 1'b0;

			cv_s1 <= (state_q == ST_CMP);
			pv_s1 <= (state_q == ST_PEEL);

			// domination column of individual i, built one pair per cycle
			if (cv_s1) begin
				if (clast_s1)
					acc_q <= '0;
				else if (dom_bit)
					acc_q <= acc_q | (POP_SIZE'(1) << cj_s1);
			end

			if (hit && (cur_q == '0))
				front_q <= front_q + CW'(1);

			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						if (loaded_q < CW'(POP_SIZE))
							loaded_q <= loaded_q + CW'(1);
						else
							overflow_q <= 1'b1;
						if (s_tlast) begin
							state_q <= ST_CMP;
							ci_q    <= '0;
							cj_q    <= '0;
							cur_q   <= '0;
							front_q <= '0;
							acc_q   <= '0;
							done_q  <= '0;
							newly_q <= '0;
						end
					end
				end
				ST_CMP: begin
					ci_s1    <= ci_q;
					cj_s1    <= cj_q;
					clast_s1 <= (cj_q == last_idx);
					if (cj_q == last_idx) begin
						cj_q <= '0;
						if (ci_q == last_idx)
							state_q <= ST_CMP_END;
						else
							ci_q <= ci_q + IW'(1);
					end else begin
						cj_q <= cj_q + IW'(1);
					end
				end
				ST_CMP_END: begin
					state_q <= ST_PEEL;
					pi_q    <= '0;
				end
				ST_PEEL: begin
					if (hit)
						newly_q <= newly_next;
					pi_s1    <= pi_q;
					if (pi_q == last_idx)
						state_q <= ST_PEEL_END;
					else
						pi_q <= pi_q + IW'(1);
				end
				ST_PEEL_END: begin
					done_q  <= done_next;
					newly_q <= '0;
					pi_q    <= '0;
					if (all_done) begin
						state_q <= ST_EMIT_RD;
						p_q     <= '0;
					end else begin
						state_q <= ST_PEEL;
						cur_q   <= cur_q + IW'(1);
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_WR;
				end
				ST_EMIT_WR: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						m_last_q  <= (p_q == last_idx);
						m_data_q  <= OUT_DATA_W'({overflow_q, FRONT_W'(front_q),
							RANK_W'(cur_q), (rank_rd_s1 == '0),
							RANK_W'(rank_rd_s1), POS_W'(p_q)});
						if (p_q == last_idx) begin
							state_q    <= ST_IDLE;
							loaded_q   <= '0;
							overflow_q <= 1'b0;
						end else begin
							state_q <= ST_EMIT_RD;
							p_q     <= p_q + IW'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* dv/pareto_nondominated_rank_sorter_top_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the Pareto rank sorter: streams populations in,
// predicts every rank result and checks each one. Depends on pnrs_pkg and the top level.
module pareto_nondominated_rank_sorter_top_test;
	import pnrs_pkg::*;

	localparam int CAPACITY = 64;
	localparam int STALL_LIMIT = 200000;
	localparam logic [2:0] OBJ_COUNT_ADDR = 3'd0;

	typedef struct packed {
		logic       last;
		logic       ovf;
		logic [6:0] front;
		logic [5:0] highest;
		logic       in_front;
		logic [5:0] rank;
		logic [5:0] pos;
	} rank_res_t;

	typedef struct packed {
		indiv_t    ind;
		logic      fin;
		logic      typed;
		rank_res_t res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic m_tlast;

	pareto_nondominated_rank_sorter_top dut (.*);

	always #5 clk = ~clk;

	indiv_t    population[$];
	logic      pop_ovf;
	logic [2:0] obj_count_q = 3'd2;
	rank_res_t ranks_due[$];
	int errors = 0;
	int idle_pct = 0, stall_pct = 0;
	int results_seen = 0, items_sent = 0, populations = 0, quiet = 0;

	task automatic note_error(string msg);
		errors++;
		if (errors <= 10)
			$display("mismatch: %s", msg);
	endtask

	function automatic bit loses_to(indiv_t a, indiv_t b);
		int n;
		bit all_eq;
		n = (obj_count_q > NUM_OBJ) ? NUM_OBJ : obj_count_q;
		all_eq = 1'b1;
		for (int k = 0; k < n; k++) begin
			if ($signed(a.obj[k]) < $signed(b.obj[k]))
				return 1'b0;
			if (a.obj[k] != b.obj[k])
				all_eq = 1'b0;
		end
		if (all_eq)
			return a.ident < b.ident;
		return 1'b1;
	endfunction

	task automatic rank_population();
		int n, highest, front;
		int beaten_by[CAPACITY];
		bit beats[CAPACITY][CAPACITY];
		int rk[CAPACITY];
		bit ranked[CAPACITY];
		bit progress;
		rank_res_t r;
		n = population.size();
		highest = 0;
		front = 0;
		progress = 1'b1;
		for (int i = 0; i < n; i++) begin
			beaten_by[i] = 0;
			ranked[i] = 1'b0;
			rk[i] = 0;
			for (int j = 0; j < n; j++)
				beats[i][j] = 1'b0;
		end
		for (int i = 0; i < n; i++)
			for (int j = 0; j < n; j++)
				if (i != j && loses_to(population[i], population[j])) begin
					beats[j][i] = 1'b1;
					beaten_by[i]++;
				end
		for (int cur = 0; cur < n && progress; cur++) begin
			progress = 1'b0;
			for (int i = 0; i < n; i++)
				if (!ranked[i] && beaten_by[i] == 0) begin
					ranked[i] = 1'b1;
					rk[i] = cur;
					highest = cur;
				end
			for (int i = 0; i < n; i++)
				if (ranked[i] && rk[i] == cur)
					for (int j = 0; j < n; j++)
						if (beats[i][j] && beaten_by[j] > 0) begin
							beaten_by[j]--;
							progress = 1'b1;
						end
		end
		for (int i = 0; i < n; i++)
			if (ranked[i] && rk[i] == 0)
				front++;
		for (int i = 0; i < n; i++) begin
			r.pos = i[5:0];
			r.rank = rk[i][5:0];
			r.in_front = (rk[i] == 0);
			r.highest = highest[5:0];
			r.front = front[6:0];
			r.ovf = pop_ovf;
			r.last = (i + 1 == n);
			ranks_due = {ranks_due, r};
		end
		population.delete();
		pop_ovf = 1'b0;
		populations++;
	endtask

	task automatic send_item(indiv_t v, logic fin);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= v;
		s_tlast <= fin;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		if (population.size() < CAPACITY)
			population = {population, v};
		else
			pop_ovf = 1'b1;
		if (fin)
			rank_population();
	endtask

	task automatic write_obj_count(logic [31:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= OBJ_COUNT_ADDR;
		pwdata <= val;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[2:0] !== val[2:0])
			note_error($sformatf("objective_count read %0d, wrote %0d", prdata[2:0], val[2:0]));
		psel <= 1'b0;
		penable <= 1'b0;
		obj_count_q = val[2:0];
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (ranks_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(3))
			0: return 32'($signed($urandom_range(4)) - 2);
			1: return $urandom;
			2: case ($urandom_range(2))
				0: return 32'h8000_0000;
				1: return 32'h7fff_ffff;
				default: return 32'h0;
			endcase
			default: return {16'($urandom_range(3)), 16'h0};
		endcase
	endfunction

	function automatic indiv_t pick_indiv();
		indiv_t v;
		v.ident = $urandom_range(1) ? $urandom : 32'($urandom_range(3));
		for (int k = 0; k < NUM_OBJ; k++)
			v.obj[k] = pick_value();
		return v;
	endfunction

	function automatic indiv_t mk(logic [31:0] id, logic [31:0] a, logic [31:0] b,
			logic [31:0] c, logic [31:0] d);
		indiv_t v;
		v.ident = id;
		v.obj[0] = a;
		v.obj[1] = b;
		v.obj[2] = c;
		v.obj[3] = d;
		return v;
	endfunction

	row_t directed[$];
	rank_res_t solo;

	always @(posedge clk) begin
		rank_res_t got, want;
		if (m_tvalid && m_tready) begin
			got = {m_tlast, m_tdata[26:0]};
			results_seen++;
			if (ranks_due.size() == 0)
				note_error($sformatf("unexpected result %h", got));
			else begin
				want = ranks_due.pop_front();
				if (got !== want)
					note_error($sformatf({"pos %0d rank %0d/%0d front %0d/%0d hi %0d/%0d",
						" ovf %0d/%0d last %0d/%0d in_front %0d/%0d"},
						got.pos, got.rank, want.rank, got.front, want.front, got.highest,
						want.highest, got.ovf, want.ovf, got.last, want.last,
						got.in_front, want.in_front));
				else if (got.pos !== want.pos)
					note_error("position");
			end
		end
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n || psel)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("timeout after %0d idle cycles", quiet);
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		int size;
		logic [31:0] counts[6];
		pop_ovf = 1'b0;
		counts = '{32'd0, 32'd1, 32'd4, 32'd7, 32'd3, 32'd2};
		solo = '{last: 1'b1, ovf: 1'b0, front: 7'd1, highest: 6'd0, in_front: 1'b1,
			rank: 6'd0, pos: 6'd0};
		directed = '{
			'{mk(0, 0, 0, 0, 0), 1'b1, 1'b1, solo},
			'{mk(32'hffff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
				32'h8000_0000), 1'b1, 1'b1, solo},
			'{mk(0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff),
				1'b1, 1'b1, solo},
			'{mk(5, 7, 7, 1, 1), 1'b0, 1'b0, '0},
			'{mk(9, 7, 7, 2, 2), 1'b1, 1'b0, '0},
			'{mk(4, 3, 3, 0, 0), 1'b0, 1'b0, '0},
			'{mk(4, 3, 3, 0, 0), 1'b1, 1'b0, '0},
			'{mk(1, 1, 1, 0, 0), 1'b0, 1'b0, '0},
			'{mk(2, 2, 2, 0, 0), 1'b0, 1'b0, '0},
			'{mk(3, 3, 3, 0, 0), 1'b1, 1'b0, '0},
			'{mk(1, 1, 3, 0, 0), 1'b0, 1'b0, '0},
			'{mk(2, 3, 1, 0, 0), 1'b0, 1'b0, '0},
			'{mk(3, 2, 2, 0, 0), 1'b0, 1'b0, '0},
			'{mk(4, 32'hffff_ffff, 32'h8000_0000, 9, 9), 1'b0, 1'b0, '0},
			'{mk(5, 32'h8000_0000, 32'hffff_ffff, 9, 9), 1'b1, 1'b0, '0}
		};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i]) begin
			send_item(directed[i].ind, directed[i].fin);
			if (directed[i].typed)
				ranks_due[ranks_due.size() - 1] = directed[i].res;
		end
		drain();
		for (int p = 0; p < 6; p++) begin
			write_obj_count(counts[p]);
			case (p % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 79; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 79; end
				default: begin idle_pct = 6; stall_pct = 6; end
			endcase
			if (p == 2) begin
				for (int i = 0; i < CAPACITY + 5; i++)
					send_item(pick_indiv(), i == CAPACITY + 4);
			end
			for (int q = items_sent + 24; items_sent < q; ) begin
				size = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
				for (int i = 0; i < size; i++)
					send_item(pick_indiv(), i == size - 1);
			end
			drain();
		end
		idle_pct = 0;
		stall_pct = 0;
		drain();
		$display("covered %0d items in %0d populations, %0d rank results checked",
			items_sent, populations, results_seen);
		$display("objective counts 0 to 4 and 7 exercised, capacity overflow and ties included");
		if (errors == 0)
			$display("TB_OK");
		else begin
			$display("%0d mismatches", errors);
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
